// ----- design/dnsqp_pkg.sv -----
// ----------------------------------------------------------------------------
// dnsqp_pkg
// shared constants and types for the dns question name parser
// ----------------------------------------------------------------------------
package dnsqp_pkg;

  localparam int unsigned MAX_NAME_CHARS = 255;
  localparam int unsigned HEADER_BYTES   = 12;
  localparam logic [7:0]  DOT_CHAR       = 8'h2E;

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_LENGTH   = 3'd1;
  localparam logic [2:0] PH_LABEL    = 3'd2;
  localparam logic [2:0] PH_TYPE_HI  = 3'd3;
  localparam logic [2:0] PH_TYPE_LO  = 3'd4;
  localparam logic [2:0] PH_CLASS_HI = 3'd5;
  localparam logic [2:0] PH_CLASS_LO = 3'd6;
  localparam logic [2:0] PH_DRAIN    = 3'd7;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam int unsigned OUT_DATA_W = 64;

  typedef struct packed {
    logic [1:0]            kind;
    logic [OUT_DATA_W-1:0] data;
  } result_t;

endpackage

// ----- design/dns_question_name_parser_core.sv -----
// ----------------------------------------------------------------------------
// dns_question_name_parser_core
// walks a dns query byte stream, emits the dotted question name one
// character per word, then one completion or error word per packet
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  in_*      in   tvalid/tready       tdata = packet byte, tlast = last byte
//  out_*     out  tvalid/tready       tuser = kind, tdata = char/id/type/class/len
//
//  one byte accepted per cycle while in_tready is high; its result word (if
//  any) is registered in the output register, or in the skid entry if held
//  a two-entry output stage (output register plus skid) lets input flow
//  while a result waits; in_tready drops only when both entries are full
//  synchronous active-low reset returns the parser to the header phase
// ----------------------------------------------------------------------------
module dns_question_name_parser_core
  import dnsqp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // packet_byte
  input  logic        in_tlast,   // packet_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // name_char, query_id, query_type, query_class, name_length
  output logic [1:0]  out_tuser   // result_kind
);

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic        seen_r, seen_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] type_r, type_nxt;
  logic [7:0]  class_hi_r, class_hi_nxt;
  logic [7:0]  count_r, count_nxt;

  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  result_t res;
  logic    res_valid;
  logic    in_fire;

  logic       have_char, done, err, full;
  logic [7:0] chr;
  logic [15:0] qclass;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign full      = 32'(count_r) >= MAX_NAME_CHARS;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    remain_nxt   = remain_r;
    seen_nxt     = seen_r;
    id_nxt       = id_r;
    type_nxt     = type_r;
    class_hi_nxt = class_hi_r;
    count_nxt    = count_r;
    have_char    = 1'b0;
    done         = 1'b0;
    err          = 1'b0;
    chr          = '0;
    qclass       = '0;
    unique case (phase_r)
      PH_HEADER: begin
        if (pos_r == 4'd0) id_nxt[15:8] = in_tdata;
        else if (pos_r == 4'd1) id_nxt[7:0] = in_tdata;
        if (32'(pos_r) + 1 >= HEADER_BYTES) phase_nxt = PH_LENGTH;
        else pos_nxt = pos_r + 4'd1;
      end
      PH_LENGTH: begin
        if (in_tdata == 8'd0) begin
          phase_nxt = PH_TYPE_HI;
        end else begin
          remain_nxt = in_tdata;
          phase_nxt  = PH_LABEL;
          if (seen_r) begin
            if (full) begin
              err = 1'b1;
            end else begin
              have_char = 1'b1;
              chr       = DOT_CHAR;
              count_nxt = count_r + 8'd1;
            end
          end
          seen_nxt = 1'b1;
        end
      end
      PH_LABEL: begin
        if (full) begin
          err = 1'b1;
        end else begin
          have_char = 1'b1;
          chr       = in_tdata;
          count_nxt = count_r + 8'd1;
        end
        remain_nxt = remain_r - 8'd1;
        if (remain_r == 8'd1) phase_nxt = PH_LENGTH;
      end
      PH_TYPE_HI: begin
        type_nxt[15:8] = in_tdata;
        phase_nxt      = PH_TYPE_LO;
      end
      PH_TYPE_LO: begin
        type_nxt[7:0] = in_tdata;
        phase_nxt     = PH_CLASS_HI;
      end
      PH_CLASS_HI: begin
        class_hi_nxt = in_tdata;
        phase_nxt    = PH_CLASS_LO;
      end
      PH_CLASS_LO: begin
        qclass    = {class_hi_r, in_tdata};
        done      = 1'b1;
        phase_nxt = PH_DRAIN;
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    if (in_tlast && phase_r != PH_DRAIN && !done) err = 1'b1;
    if (err) begin
      have_char = 1'b0;
      phase_nxt = PH_DRAIN;
    end

    res.kind  = KIND_CHAR;
    res.data  = '0;
    if (err) begin
      res.kind = KIND_ERROR;
    end else if (done) begin
      res.kind = KIND_DONE;
      res.data = {count_r, qclass, type_r, id_r, 8'd0};
    end else if (have_char) begin
      res.data = {56'd0, chr};
    end
    res_valid = in_fire && (err || done || have_char);

    if (in_tlast) begin
      phase_nxt    = PH_HEADER;
      pos_nxt      = '0;
      remain_nxt   = '0;
      seen_nxt     = 1'b0;
      id_nxt       = '0;
      type_nxt     = '0;
      class_hi_nxt = '0;
      count_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      remain_r   <= '0;
      seen_r     <= 1'b0;
      id_r       <= '0;
      type_r     <= '0;
      class_hi_r <= '0;
      count_r    <= '0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      remain_r   <= remain_nxt;
      seen_r     <= seen_nxt;
      id_r       <= id_nxt;
      type_r     <= type_nxt;
      class_hi_r <= class_hi_nxt;
      count_r    <= count_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (out_valid_r) begin
      if (res_valid) skid_valid_r <= 1'b1;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_tready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (out_valid_r) begin
      if (res_valid) skid_r <= res;
    end else begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.kind;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_ERROR) |-> out_tdata == '0)
    else $error("error word carries payload");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (phase_r == PH_HEADER && count_r == 8'd0))
    else $error("parser not restarted after last byte");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_CHAR || out_tuser == KIND_DONE ||
                    out_tuser == KIND_ERROR))
    else $error("illegal result kind");

endmodule
